// ----- sv/sqn_pkg.sv -----
// Shared types, constants and codes for the square and noise tone mixer.
`timescale 1ns / 1ps

package sqn_pkg;

    // Fixed geometry of the generator
    localparam int NUM_CHANNELS       = 4;
    localparam int CH_W               = 2;
    localparam int FREQ_W             = 16;
    localparam int VOL_W              = 8;
    localparam int SAMPLE_W           = 16;
    localparam int LFSR_W             = 16;
    localparam int NOISE_CH           = NUM_CHANNELS - 1;

    // Defaults for the top-level parameters
    localparam int SAMPLE_RATE_HZ_DEF = 22050;
    localparam int PHASE_BITS_DEF     = 16;

    // Volume full scale and noise register seed
    localparam logic [VOL_W-1:0]  VOL_FULL   = 8'd240;
    localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hACE1;

    // Sum of four signed channel levels of at most 240 each
    localparam int SUM_W              = 11;

    // Output scaling: floor(mag * 125 / 6) as a multiply by a rounded-up reciprocal
    localparam int SCALE_SHIFT        = 14;
    localparam int SCALE_MULT         = (125 * (2 ** SCALE_SHIFT) + 5) / 6;
    localparam int SCALE_MULT_W       = 19;
    localparam logic [SAMPLE_W-1:0] PCM_LIMIT = 16'd32767;

    // Extra fraction bits of the frequency-to-increment reciprocal
    localparam int RECIP_GUARD        = 34;

    // Input word kinds
    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SET  = 1'b1
    } cmd_t;

    // Noise level codes
    typedef enum logic [1:0] {
        NOISE_SILENT = 2'd0,
        NOISE_POS    = 2'd1,
        NOISE_NEG    = 2'd3
    } noise_code_t;

    // One input word after unpacking
    typedef struct packed {
        cmd_t              cmd;
        logic [CH_W-1:0]   channel;
        logic [FREQ_W-1:0] frequency;
        logic [VOL_W-1:0]  volume;
    } item_t;

    // Word handed to the channel bank when it leaves the input register
    typedef struct packed {
        logic  fire;
        item_t item;
    } step_t;

endpackage

// ----- sv/sqn_channels.sv -----
// Channel bank: increment and volume store, three square tones and one noise channel, mix sum.
`timescale 1ns / 1ps

module sqn_channels #(
    parameter int SAMPLE_RATE_HZ = sqn_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int PHASE_BITS     = sqn_pkg::PHASE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sqn_pkg::step_t                    step,
    output logic signed [sqn_pkg::SUM_W-1:0]  mix_sum
);

    // Increment = floor(freq * 2^PHASE_BITS / SAMPLE_RATE_HZ) via a rounded-up reciprocal
    localparam int RECIP_SHIFT = PHASE_BITS + sqn_pkg::RECIP_GUARD;
    localparam longint unsigned RECIP =
        ((longint'(1) << RECIP_SHIFT) + longint'(SAMPLE_RATE_HZ) - 1) / longint'(SAMPLE_RATE_HZ);
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = (sqn_pkg::FREQ_W + RECIP_W > RECIP_SHIFT + 1) ?
                             sqn_pkg::FREQ_W + RECIP_W : RECIP_SHIFT + 1;

    logic [PHASE_BITS-1:0]      inc_reg        [sqn_pkg::NUM_CHANNELS];
    logic [PHASE_BITS-1:0]      inc_next       [sqn_pkg::NUM_CHANNELS];
    logic [sqn_pkg::VOL_W-1:0]  weight_reg     [sqn_pkg::NUM_CHANNELS];
    logic [sqn_pkg::VOL_W-1:0]  weight_next    [sqn_pkg::NUM_CHANNELS];
    logic [PHASE_BITS-1:0]      tone_phase_reg [sqn_pkg::NOISE_CH];
    logic [PHASE_BITS-1:0]      tone_phase_next[sqn_pkg::NOISE_CH];
    logic [PHASE_BITS-1:0]      tone_sum       [sqn_pkg::NOISE_CH];
    logic [PHASE_BITS-1:0]      noise_phase_reg;
    logic [PHASE_BITS-1:0]      noise_phase_next;
    logic [PHASE_BITS-1:0]      noise_sum;
    logic                       noise_carry;
    sqn_pkg::noise_code_t       noise_level_reg;
    sqn_pkg::noise_code_t       noise_level_next;
    sqn_pkg::noise_code_t       noise_level_new;
    logic [sqn_pkg::LFSR_W-1:0] noise_shift_reg;
    logic [sqn_pkg::LFSR_W-1:0] noise_shift_next;

    logic [PROD_W-1:0]          inc_prod;
    logic                       inc_sat;
    logic [PHASE_BITS-1:0]      inc_calc;
    logic [sqn_pkg::VOL_W-1:0]  vol_calc;
    logic [sqn_pkg::NUM_CHANNELS-1:0] enable;
    logic signed [sqn_pkg::SUM_W-1:0] contrib[sqn_pkg::NUM_CHANNELS];
    logic signed [sqn_pkg::SUM_W-1:0] weight_s[sqn_pkg::NUM_CHANNELS];
    logic                       is_tick;

    // Convert a set word's frequency and clamp its volume
    assign inc_prod = PROD_W'(step.item.frequency) * PROD_W'(RECIP);
    assign inc_sat  = |inc_prod[PROD_W-1:RECIP_SHIFT];
    assign inc_calc = inc_sat ? {PHASE_BITS{1'b1}}
                              : inc_prod[RECIP_SHIFT-1:sqn_pkg::RECIP_GUARD];
    assign vol_calc = (step.item.volume > sqn_pkg::VOL_FULL) ? sqn_pkg::VOL_FULL
                                                             : step.item.volume;

    assign is_tick = step.fire && (step.item.cmd == sqn_pkg::CMD_TICK);

    // Advance phases and find each channel's level
    always_comb
    begin
        for (int c = 0; c < sqn_pkg::NUM_CHANNELS; c++)
        begin
            enable[c]   = (weight_reg[c] != '0) && (inc_reg[c] != '0);
            weight_s[c] = $signed(sqn_pkg::SUM_W'(weight_reg[c]));
        end
        for (int c = 0; c < sqn_pkg::NOISE_CH; c++)
        begin
            tone_sum[c] = tone_phase_reg[c] + inc_reg[c];
        end
        {noise_carry, noise_sum} = {1'b0, noise_phase_reg} +
                                   {1'b0, inc_reg[sqn_pkg::NOISE_CH]};
        if (noise_carry)
        begin
            noise_level_new = noise_shift_reg[0] ? sqn_pkg::NOISE_POS : sqn_pkg::NOISE_NEG;
        end
        else
        begin
            noise_level_new = noise_level_reg;
        end
    end

    // Weigh the levels and add them up
    always_comb
    begin
        for (int c = 0; c < sqn_pkg::NOISE_CH; c++)
        begin
            if (!enable[c])
            begin
                contrib[c] = '0;
            end
            else if (tone_sum[c][PHASE_BITS-1])
            begin
                contrib[c] = -weight_s[c];
            end
            else
            begin
                contrib[c] = weight_s[c];
            end
        end
        contrib[sqn_pkg::NOISE_CH] = '0;
        if (enable[sqn_pkg::NOISE_CH])
        begin
            unique case (noise_level_new)
                sqn_pkg::NOISE_POS: contrib[sqn_pkg::NOISE_CH] = weight_s[sqn_pkg::NOISE_CH];
                sqn_pkg::NOISE_NEG: contrib[sqn_pkg::NOISE_CH] = -weight_s[sqn_pkg::NOISE_CH];
                default:            contrib[sqn_pkg::NOISE_CH] = '0;
            endcase
        end
        mix_sum = contrib[0] + contrib[1] + contrib[2] + contrib[3];
    end

    // Next state for set and tick words
    always_comb
    begin
        inc_next         = inc_reg;
        weight_next      = weight_reg;
        tone_phase_next  = tone_phase_reg;
        noise_phase_next = noise_phase_reg;
        noise_level_next = noise_level_reg;
        noise_shift_next = noise_shift_reg;
        if (step.fire && (step.item.cmd == sqn_pkg::CMD_SET))
        begin
            inc_next[step.item.channel]    = inc_calc;
            weight_next[step.item.channel] = vol_calc;
        end
        else if (is_tick)
        begin
            for (int c = 0; c < sqn_pkg::NOISE_CH; c++)
            begin
                if (enable[c])
                begin
                    tone_phase_next[c] = tone_sum[c];
                end
            end
            if (enable[sqn_pkg::NOISE_CH])
            begin
                noise_phase_next = noise_sum;
                noise_level_next = noise_level_new;
                if (noise_carry)
                begin
                    noise_shift_next = {noise_shift_reg[0] ^ noise_shift_reg[1],
                                        noise_shift_reg[sqn_pkg::LFSR_W-1:1]};
                end
            end
        end
    end

    // Hold channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < sqn_pkg::NUM_CHANNELS; c++)
            begin
                inc_reg[c]    <= '0;
                weight_reg[c] <= '0;
            end
            for (int c = 0; c < sqn_pkg::NOISE_CH; c++)
            begin
                tone_phase_reg[c] <= '0;
            end
            noise_phase_reg <= '0;
            noise_level_reg <= sqn_pkg::NOISE_SILENT;
            noise_shift_reg <= sqn_pkg::LFSR_SEED;
        end
        else
        begin
            inc_reg         <= inc_next;
            weight_reg      <= weight_next;
            tone_phase_reg  <= tone_phase_next;
            noise_phase_reg <= noise_phase_next;
            noise_level_reg <= noise_level_next;
            noise_shift_reg <= noise_shift_next;
        end
    end

    // The noise register never falls into the all-zero lockup
    assert property (@(posedge clk) disable iff (!rst_n) noise_shift_reg != '0)
        else $error("noise shift register reached zero");

endmodule

// ----- sv/sqn_scale.sv -----
// Output scaler: mix sum times 125/6, truncated toward zero and clamped to the PCM range.
`timescale 1ns / 1ps

module sqn_scale (
    input  logic signed [sqn_pkg::SUM_W-1:0]    mix_sum,
    output logic signed [sqn_pkg::SAMPLE_W-1:0] sample
);

    localparam int PROD_W = sqn_pkg::SUM_W + sqn_pkg::SCALE_MULT_W;

    logic                           neg;
    logic [sqn_pkg::SUM_W-1:0]      mag;
    logic [PROD_W-1:0]              prod;
    logic [sqn_pkg::SAMPLE_W-1:0]   scaled;
    logic [sqn_pkg::SAMPLE_W-1:0]   clamped;

    // Scale the magnitude, then restore the sign
    assign neg     = mix_sum[sqn_pkg::SUM_W-1];
    assign mag     = neg ? sqn_pkg::SUM_W'(-mix_sum) : sqn_pkg::SUM_W'(mix_sum);
    assign prod    = PROD_W'(mag) * PROD_W'(sqn_pkg::SCALE_MULT);
    assign scaled  = prod[sqn_pkg::SCALE_SHIFT +: sqn_pkg::SAMPLE_W];
    assign clamped = (scaled > sqn_pkg::PCM_LIMIT) ? sqn_pkg::PCM_LIMIT : scaled;
    assign sample  = neg ? -$signed(clamped) : $signed(clamped);

endmodule

// ----- sv/square_and_noise_tone_mixer.sv -----
// Top level of the four-channel square and noise tone mixer with stream ports.
`timescale 1ns / 1ps

// Four-channel sound generator: three square tones and one LFSR noise channel.
// Each input word is either a set word (cmd=1), which stores one channel's
// frequency as a phase increment and its volume clamped to 240, or a tick
// word (cmd=0), which advances every enabled channel and yields one signed
// 16-bit sample on the output stream. Set words yield no output word. The
// block accepts one word per clock cycle while the input is not stalled. A word
// accepted into the input register is worked through the channel bank and
// scaler when it leaves that register. A tick word leaves it only when the
// result register is free; its sample is then registered in the result
// register and m_tvalid is set. A tick word waits in the input register
// while the result register holds a sample that is not taken, and only
// then is the input stalled; set words always move on. No clearing pass is
// needed after reset.

module square_and_noise_tone_mixer #(
    parameter int SAMPLE_RATE_HZ = sqn_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int PHASE_BITS     = sqn_pkg::PHASE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] frequency, [23:16] volume
    input  logic [2:0]  s_tuser,   // [0] cmd, [2:1] channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] sample
);

    logic                                 in_valid_reg;
    logic                                 in_valid_next;
    sqn_pkg::item_t                       in_item_reg;
    sqn_pkg::item_t                       in_item_next;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic signed [sqn_pkg::SAMPLE_W-1:0]  out_sample_reg;
    logic signed [sqn_pkg::SAMPLE_W-1:0]  out_sample_next;

    logic                                 s_accept;
    logic                                 out_free;
    logic                                 proc_adv;
    logic                                 proc_tick;
    sqn_pkg::step_t                       step;
    logic signed [sqn_pkg::SUM_W-1:0]     mix_sum;
    logic signed [sqn_pkg::SAMPLE_W-1:0]  sample;

    // Handshake: a word leaves the input register when it needs no output slot or one is free
    assign out_free  = !out_valid_reg || m_tready;
    assign proc_adv  = in_valid_reg && ((in_item_reg.cmd == sqn_pkg::CMD_SET) || out_free);
    assign proc_tick = proc_adv && (in_item_reg.cmd == sqn_pkg::CMD_TICK);
    assign s_tready  = !in_valid_reg || proc_adv;
    assign s_accept  = s_tvalid && s_tready;

    assign step = {proc_adv, in_item_reg};

    sqn_channels #(
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
        .PHASE_BITS     (PHASE_BITS)
    ) u_channels (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .mix_sum (mix_sum)
    );

    sqn_scale u_scale (
        .mix_sum (mix_sum),
        .sample  (sample)
    );

    // Load, hold or drain the input and result registers
    always_comb
    begin
        in_item_next.cmd       = sqn_pkg::cmd_t'(s_tuser[0]);
        in_item_next.channel   = s_tuser[2:1];
        in_item_next.frequency = s_tdata[15:0];
        in_item_next.volume    = s_tdata[23:16];

        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc_adv)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        out_sample_next = out_sample_reg;
        if (proc_tick)
        begin
            out_valid_next  = 1'b1;
            out_sample_next = sample;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= in_item_next;
        end
        out_sample_reg <= out_sample_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;

    // A new output word comes only from a tick word leaving the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc_tick))
        else $error("output word without a tick");

    // An empty input register always takes a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");

    // A waiting input word that needs the output slot does not leave while it is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && (in_item_reg.cmd == sqn_pkg::CMD_TICK) && out_valid_reg && !m_tready)
        |-> !proc_adv)
        else $error("tick word overran the result register");

    // The clamped sample never reaches the most negative code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_sample_reg != {1'b1, {(sqn_pkg::SAMPLE_W-1){1'b0}}}))
        else $error("sample outside the PCM range");

endmodule

// ----- verif/tb_square_and_noise_tone_mixer.sv -----
// Self-checking testbench for the square and noise tone mixer: directed table, then random words.
`timescale 1ns / 1ps

module tb_square_and_noise_tone_mixer;

    localparam int RATE_HZ   = sqn_pkg::SAMPLE_RATE_HZ_DEF;
    localparam int PH_BITS   = sqn_pkg::PHASE_BITS_DEF;
    localparam int RAND_WORDS = 1625;
    localparam int CALM_WORDS = 200;
    localparam int HOLD_AT    = 800;

    // One row of the directed stimulus table
    typedef struct packed {
        sqn_pkg::cmd_t                cmd;
        logic [sqn_pkg::CH_W-1:0]     channel;
        logic [sqn_pkg::FREQ_W-1:0]   frequency;
        logic [sqn_pkg::VOL_W-1:0]    volume;
        logic                         typed;
        logic [sqn_pkg::SAMPLE_W-1:0] want;
    } stim_row_t;

    localparam int DIR_ROWS = 25;

    // Extremes, every channel, both disable paths, LFSR clocking, then silence
    stim_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{sqn_pkg::CMD_TICK, 2'd0, 16'd0,     8'd0,   1'b1, 16'd0},
        '{sqn_pkg::CMD_SET,  2'd0, 16'hFFFF,  8'd255, 1'b0, 16'd0},
        '{sqn_pkg::CMD_TICK, 2'd0, 16'd0,     8'd0,   1'b1, 16'hEC78},
        '{sqn_pkg::CMD_TICK, 2'd3, 16'hFFFF,  8'd255, 1'b0, 16'd0},
        '{sqn_pkg::CMD_SET,  2'd1, 16'd11025, 8'd240, 1'b0, 16'd0},
        '{sqn_pkg::CMD_TICK, 2'd0, 16'd0,     8'd0,   1'b0, 16'd0},
        '{sqn_pkg::CMD_SET,  2'd2, 16'd1,     8'd1,   1'b0, 16'd0},
        '{sqn_pkg::CMD_SET,  2'd3, 16'd22050, 8'd128, 1'b0, 16'd0},
        '{sqn_pkg::CMD_TICK, 2'd0, 16'd0,     8'd0,   1'b0, 16'd0},
        '{sqn_pkg::CMD_TICK, 2'd0, 16'd0,     8'd0,   1'b0, 16'd0},
        '{sqn_pkg::CMD_TICK, 2'd0, 16'd0,     8'd0,   1'b0, 16'd0},
        '{sqn_pkg::CMD_SET,  2'd0, 16'd0,     8'd200, 1'b0, 16'd0},
        '{sqn_pkg::CMD_SET,  2'd1, 16'd5000,  8'd0,   1'b0, 16'd0},
        '{sqn_pkg::CMD_TICK, 2'd0, 16'd0,     8'd0,   1'b0, 16'd0},
        '{sqn_pkg::CMD_SET,  2'd3, 16'hFFFF,  8'd255, 1'b0, 16'd0},
        '{sqn_pkg::CMD_TICK, 2'd0, 16'd0,     8'd0,   1'b0, 16'd0},
        '{sqn_pkg::CMD_TICK, 2'd0, 16'd0,     8'd0,   1'b0, 16'd0},
        '{sqn_pkg::CMD_SET,  2'd2, 16'h8000,  8'hAA,  1'b0, 16'd0},
        '{sqn_pkg::CMD_SET,  2'd1, 16'h5555,  8'h55,  1'b0, 16'd0},
        '{sqn_pkg::CMD_TICK, 2'd0, 16'd0,     8'd0,   1'b0, 16'd0},
        '{sqn_pkg::CMD_SET,  2'd0, 16'd0,     8'd0,   1'b0, 16'd0},
        '{sqn_pkg::CMD_SET,  2'd1, 16'd0,     8'd0,   1'b0, 16'd0},
        '{sqn_pkg::CMD_SET,  2'd2, 16'd0,     8'd0,   1'b0, 16'd0},
        '{sqn_pkg::CMD_SET,  2'd3, 16'd0,     8'd0,   1'b0, 16'd0},
        '{sqn_pkg::CMD_TICK, 2'd0, 16'd0,     8'd0,   1'b1, 16'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [15:0] frequency, [23:16] volume
    logic [2:0]  s_tuser = '0;   // [0] cmd, [2:1] channel
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [15:0] sample

    // Mirror of the generator state
    logic [15:0]           chan_inc    [sqn_pkg::NUM_CHANNELS];
    logic [7:0]            chan_weight [sqn_pkg::NUM_CHANNELS];
    logic [15:0]           tone_acc    [sqn_pkg::NUM_CHANNELS-1];
    logic [15:0]           noise_acc;
    sqn_pkg::noise_code_t  noise_state;
    logic [15:0]           noise_lfsr;

    logic [sqn_pkg::SAMPLE_W-1:0] pending_samples [$];
    int  mismatch_count = 0;
    bit  calm = 1'b0;
    bit  ready_started = 1'b0;

    square_and_noise_tone_mixer #(
        .SAMPLE_RATE_HZ (RATE_HZ),
        .PHASE_BITS     (PH_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Count a failure and print it
    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Clear the mirror to its reset contents
    task automatic clear_mixer_state();
        for (int c = 0; c < sqn_pkg::NUM_CHANNELS; c++)
        begin
            chan_inc[c]    = '0;
            chan_weight[c] = '0;
        end
        for (int c = 0; c < sqn_pkg::NUM_CHANNELS - 1; c++)
            tone_acc[c] = '0;
        noise_acc   = '0;
        noise_state = sqn_pkg::NOISE_SILENT;
        noise_lfsr  = sqn_pkg::LFSR_SEED;
    endtask

    // Store one channel: increment floored and saturated, volume clamped
    task automatic store_channel(input logic [1:0] ch, input logic [15:0] freq,
                                 input logic [7:0] vol);
        longint unsigned q;
        q = 64'(freq);
        q = (q << PH_BITS) / RATE_HZ;
        if (q > 64'hFFFF)
            q = 64'hFFFF;
        chan_inc[ch]    = q[15:0];
        chan_weight[ch] = (vol > sqn_pkg::VOL_FULL) ? sqn_pkg::VOL_FULL : vol;
    endtask

    // Advance every enabled channel and mix one sample
    function automatic logic [15:0] mix_next_sample();
        int          sum;
        int          lvl;
        int          mag;
        int          res;
        logic [16:0] acc;
        logic        fb;
        sum = 0;
        for (int c = 0; c < sqn_pkg::NUM_CHANNELS; c++)
        begin
            if (chan_weight[c] != 0 && chan_inc[c] != 0)
            begin
                if (c < sqn_pkg::NOISE_CH)
                begin
                    tone_acc[c] = tone_acc[c] + chan_inc[c];
                    lvl = tone_acc[c][15] ? -1 : 1;
                end
                else
                begin
                    acc = {1'b0, noise_acc} + {1'b0, chan_inc[c]};
                    // Clock the LFSR on a carry out of the phase
                    if (acc[16])
                    begin
                        fb = noise_lfsr[0] ^ noise_lfsr[1];
                        noise_state = noise_lfsr[0] ? sqn_pkg::NOISE_POS : sqn_pkg::NOISE_NEG;
                        noise_lfsr  = {fb, noise_lfsr[15:1]};
                    end
                    noise_acc = acc[15:0];
                    case (noise_state)
                        sqn_pkg::NOISE_POS: lvl = 1;
                        sqn_pkg::NOISE_NEG: lvl = -1;
                        default:            lvl = 0;
                    endcase
                end
                sum += lvl * int'(chan_weight[c]);
            end
        end
        mag = (sum < 0) ? -sum : sum;
        mag = (mag * 125) / 6;
        if (mag > 32767)
            mag = 32767;
        res = (sum < 0) ? -mag : mag;
        return res[15:0];
    endfunction

    // Offer one word, hold it until taken, then update the expected samples
    task automatic send_word(input sqn_pkg::cmd_t cmd, input logic [1:0] ch,
                             input logic [15:0] freq, input logic [7:0] vol,
                             input logic typed, input logic [15:0] want);
        logic [15:0] predicted;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {vol, freq};
        s_tuser  = {ch, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        if (cmd == sqn_pkg::CMD_SET)
            store_channel(ch, freq, vol);
        else
        begin
            predicted = mix_next_sample();
            pending_samples.push_back(typed ? want : predicted);
        end
        @(negedge clk);
    endtask

    // Random output stalls in bursts, steady ready during the calm tail
    initial
    begin
        wait (ready_started);
        forever
        begin
            if (calm)
            begin
                m_tready = 1'b1;
                @(negedge clk);
            end
            else
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                m_tready = 1'b1;
                repeat ($urandom_range(1, 24)) @(negedge clk);
            end
        end
    end

    // Compare each accepted sample with the oldest expectation
    always @(posedge clk)
    begin
        logic [15:0] exp_sample;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_samples.size() == 0)
                flag_mismatch($sformatf("unexpected sample %0d", $signed(m_tdata)));
            else
            begin
                exp_sample = pending_samples.pop_front();
                if (m_tdata !== exp_sample)
                    flag_mismatch($sformatf("sample %0d, expected %0d",
                                            $signed(m_tdata), $signed(exp_sample)));
            end
        end
    end

    // Stimulus: reset, directed table, random words, drain
    initial
    begin
        sqn_pkg::cmd_t r_cmd;
        logic [1:0]    r_ch;
        logic [15:0]   r_freq;
        logic [7:0]    r_vol;
        int            pick;
        int            drain;
        clear_mixer_state();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        ready_started = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_rows[i].cmd, dir_rows[i].channel, dir_rows[i].frequency,
                      dir_rows[i].volume, dir_rows[i].typed, dir_rows[i].want);

        for (int i = 0; i < RAND_WORDS; i++)
        begin
            calm = (i >= RAND_WORDS - CALM_WORDS);
            // Hold off until every sample in flight has come back
            if (i == HOLD_AT)
            begin
                s_tvalid = 1'b0;
                while (pending_samples.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            r_cmd = ($urandom_range(0, 3) == 0) ? sqn_pkg::CMD_SET : sqn_pkg::CMD_TICK;
            r_ch  = 2'($urandom_range(0, 3));
            pick  = $urandom_range(0, 9);
            if (pick < 4)
                r_freq = 16'($urandom_range(0, 65535));
            else if (pick < 8)
                r_freq = 16'($urandom_range(1, 4000));
            else if (pick == 8)
                r_freq = 16'd0;
            else
                r_freq = 16'($urandom_range(22050, 65535));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                r_vol = 8'd0;
            else if (pick == 1)
                r_vol = 8'($urandom_range(241, 255));
            else
                r_vol = 8'($urandom_range(0, 255));
            send_word(r_cmd, r_ch, r_freq, r_vol, 1'b0, 16'd0);
        end
        s_tvalid = 1'b0;

        // Drain outstanding samples, then allow the pipeline to settle
        drain = 0;
        while (pending_samples.size() != 0 && drain < 10000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (pending_samples.size() != 0)
            flag_mismatch($sformatf("%0d samples never arrived", pending_samples.size()));

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: end the run if it hangs
    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
